/* rtl/deconvolved_crrc_pulse_model_defines.svh */
// assertion macros for the pulse model, clocked on clk and disabled in reset
`ifndef DECONVOLVED_CRRC_PULSE_MODEL_DEFINES_SVH
`define DECONVOLVED_CRRC_PULSE_MODEL_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DCRRC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define DCRRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/dcrrc_pkg.sv */
package dcrrc_pkg;

	localparam int LANES = 3;
	localparam int DIV_STEPS = 18;
	localparam int TAU_MIN = 16;

	// lane 0 evaluates at x+25 ns, lane 1 at x, lane 2 at x-25 ns (Q12.4)
	localparam logic signed [16:0] LANE_DELTA [LANES] = '{17'sd400, 17'sd0, -17'sd400};

	// combining weights, Q2.14
	localparam logic signed [15:0] W_PLUS  = 16'sd19875;
	localparam logic signed [15:0] W_ZERO  = 16'sd24109;
	localparam logic signed [15:0] W_MINUS = 16'sd7312;

	typedef enum logic [2:0] {
		REG_BASELINE = 3'd0,
		REG_OFFSET   = 3'd1,
		REG_SCALE    = 3'd2,
		REG_TAU      = 3'd3,
		REG_STRETCH  = 3'd4
	} cfg_reg_t;

	// entry k of the decay table in Q1.30; a is the table step 16/N in Q.30
	function automatic logic [30:0] exp_entry(input longint unsigned a, input int k);
		longint unsigned term;
		longint sum;
		longint unsigned q;
		longint unsigned v;
		term = 64'd1 << 30;
		sum = longint'(64'd1 << 30);
		term = ((term * a) >> 30) / 64'd1;  sum = sum - longint'(term);
		term = ((term * a) >> 30) / 64'd2;  sum = sum + longint'(term);
		term = ((term * a) >> 30) / 64'd3;  sum = sum - longint'(term);
		term = ((term * a) >> 30) / 64'd4;  sum = sum + longint'(term);
		term = ((term * a) >> 30) / 64'd5;  sum = sum - longint'(term);
		term = ((term * a) >> 30) / 64'd6;  sum = sum + longint'(term);
		term = ((term * a) >> 30) / 64'd7;  sum = sum - longint'(term);
		term = ((term * a) >> 30) / 64'd8;  sum = sum + longint'(term);
		term = ((term * a) >> 30) / 64'd9;  sum = sum - longint'(term);
		term = ((term * a) >> 30) / 64'd10; sum = sum + longint'(term);
		term = ((term * a) >> 30) / 64'd11; sum = sum - longint'(term);
		term = ((term * a) >> 30) / 64'd12; sum = sum + longint'(term);
		term = ((term * a) >> 30) / 64'd13; sum = sum - longint'(term);
		term = ((term * a) >> 30) / 64'd14; sum = sum + longint'(term);
		term = ((term * a) >> 30) / 64'd15; sum = sum - longint'(term);
		term = ((term * a) >> 30) / 64'd16; sum = sum + longint'(term);
		term = ((term * a) >> 30) / 64'd17; sum = sum - longint'(term);
		term = ((term * a) >> 30) / 64'd18; sum = sum + longint'(term);
		term = ((term * a) >> 30) / 64'd19; sum = sum - longint'(term);
		term = ((term * a) >> 30) / 64'd20; sum = sum + longint'(term);
		term = ((term * a) >> 30) / 64'd21; sum = sum - longint'(term);
		term = ((term * a) >> 30) / 64'd22; sum = sum + longint'(term);
		term = ((term * a) >> 30) / 64'd23; sum = sum - longint'(term);
		term = ((term * a) >> 30) / 64'd24; sum = sum + longint'(term);
		q = (sum < 0) ? 64'd0 : longint'(sum);
		v = 64'd1 << 30;
		for (int j = 1; j <= k; j++) begin
			v = (v * q + (64'd1 << 29)) >> 30;
		end
		return v[30:0];
	endfunction

endpackage

/* rtl/deconvolved_crrc_pulse_model.sv */
// a result strobes on done once its start transfer has passed stages s1 and s2, the divider and s4 to s13
// throughput: one item per cycle, busy is always low; the 18-step restoring
// divider for t/tau sets the depth, one quotient bit per stage
// the receiver cannot stall: done is high for exactly one cycle per item
// arst_n clears all valid bits and loads the register reset values
`include "deconvolved_crrc_pulse_model_defines.svh"

module deconvolved_crrc_pulse_model #(
	parameter int EXP_TABLE_ENTRIES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  time_in,
	output logic                done,
	output logic signed [31:0]  model_value,
	output logic                saturated,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import dcrrc_pkg::*;

	localparam int IW = $clog2(EXP_TABLE_ENTRIES + 1);
	localparam longint unsigned EXP_STEP = (64'd16 << 30) / EXP_TABLE_ENTRIES;

	// configuration
	logic signed [23:0] baseline_q;
	logic signed [15:0] toff_q;
	logic signed [23:0] scale_q;
	logic [14:0]        tau_q;
	logic [15:0]        stretch_q;
	logic [14:0]        tau_eff;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign tau_eff = (tau_q < 15'(TAU_MIN)) ? 15'(TAU_MIN) : tau_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q <= 24'sd0;
			toff_q <= -16'sd560;
			scale_q <= 24'sd46080;
			tau_q <= 15'd720;
			stretch_q <= 16'd16384;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(paddr[4:2]))
				REG_BASELINE: baseline_q <= pwdata[23:0];
				REG_OFFSET:   toff_q <= pwdata[15:0];
				REG_SCALE:    scale_q <= pwdata[23:0];
				REG_TAU:      tau_q <= pwdata[14:0];
				REG_STRETCH:  stretch_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_reg_t'(paddr[4:2]))
			REG_BASELINE: prdata = {8'd0, baseline_q};
			REG_OFFSET:   prdata = {16'd0, toff_q};
			REG_SCALE:    prdata = {8'd0, scale_q};
			REG_TAU:      prdata = {17'd0, tau_q};
			REG_STRETCH:  prdata = {16'd0, stretch_q};
			default:      prdata = 32'd0;
		endcase
	end

	// decay table, constant
	logic [30:0] exp_rom [0:EXP_TABLE_ENTRIES];
	for (genvar k = 0; k <= EXP_TABLE_ENTRIES; k++) begin : g_rom
		assign exp_rom[k] = exp_entry(EXP_STEP, k);
	end

	// pipeline registers
	logic               vld_s1, vld_s2, vld_s4, vld_s5, vld_s6, vld_s7;
	logic               vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;
	logic signed [34:0] t_s1 [LANES];
	logic [32:0]        tu_s2 [LANES];
	logic               ub_s2 [LANES];
	logic               dv_vld_s3 [DIV_STEPS];
	logic [32:0]        dv_rem_s3 [DIV_STEPS][LANES];
	logic [17:0]        dv_quo_s3 [DIV_STEPS][LANES];
	logic [32:0]        dv_tu_s3 [DIV_STEPS][LANES];
	logic               dv_ub_s3 [DIV_STEPS][LANES];
	logic [IW-1:0]      i_s4 [LANES];
	logic [17:0]        f_s4 [LANES];
	logic [32:0]        tu_s4 [LANES];
	logic               ub_s4 [LANES];
	logic [30:0]        ta_s5 [LANES];
	logic [30:0]        df_s5 [LANES];
	logic [17:0]        f_s5 [LANES];
	logic [32:0]        tu_s5 [LANES];
	logic               ub_s5 [LANES];
	logic [30:0]        ta_s6 [LANES];
	logic [30:0]        dfp_s6 [LANES];
	logic [32:0]        tu_s6 [LANES];
	logic               ub_s6 [LANES];
	logic [30:0]        e_s7 [LANES];
	logic [32:0]        tu_s7 [LANES];
	logic               ub_s7 [LANES];
	logic [47:0]        pl_s8 [LANES];
	logic [46:0]        ph_s8 [LANES];
	logic               ub_s8 [LANES];
	logic [32:0]        te_s9 [LANES];
	logic               ub_s9 [LANES];
	logic signed [41:0] sl_s10 [LANES];
	logic signed [40:0] sh_s10 [LANES];
	logic               ub_s10 [LANES];
	logic signed [40:0] pulse_s11 [LANES];
	logic signed [56:0] wp_s12, wz_s12, wm_s12;
	logic signed [31:0] model_value_s13;
	logic               saturated_s13;

	// combinational helpers
	logic signed [16:0] tx [LANES];
	logic [17+IW:0]     pos_c [LANES];
	logic [48:0]        dprod_c [LANES];
	logic [63:0]        tesum_c [LANES];
	logic signed [57:0] psum_c [LANES];
	logic signed [58:0] wsum_c;
	logic signed [44:0] rnd_c;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			tx[l] = 17'(time_in) + LANE_DELTA[l];
			pos_c[l] = (18 + IW)'(dv_quo_s3[DIV_STEPS-1][l])
				* (18 + IW)'(EXP_TABLE_ENTRIES);
			dprod_c[l] = 49'(df_s5[l]) * 49'(f_s5[l]);
			tesum_c[l] = {ph_s8[l], 17'd0} + 64'(pl_s8[l]) + (64'd1 << 29);
			psum_c[l] = (58'(sh_s10[l]) <<< 17) + 58'(sl_s10[l]) + 58'sd131072;
		end
		wsum_c = 59'(wp_s12) - 59'(wz_s12) + 59'(wm_s12) + 59'sd8192;
		rnd_c = wsum_c[58:14];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s4 <= dv_vld_s3[DIV_STEPS-1];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			// stretched and shifted time, Q.18
			t_s1[l] <= 35'(tx[l]) * $signed(35'({1'b0, stretch_q}))
				+ (35'(toff_q) <<< 14);
			// before turn-on or past the table end the pulse is the baseline
			tu_s2[l] <= t_s1[l][32:0];
			ub_s2[l] <= (t_s1[l] <= 35'sd0)
				|| (t_s1[l] >= $signed({2'b00, tau_eff, 18'd0}));
			i_s4[l] <= pos_c[l][17+IW:18];
			f_s4[l] <= pos_c[l][17:0];
			tu_s4[l] <= dv_tu_s3[DIV_STEPS-1][l];
			ub_s4[l] <= dv_ub_s3[DIV_STEPS-1][l];
			ta_s5[l] <= exp_rom[i_s4[l]];
			df_s5[l] <= exp_rom[i_s4[l]] - exp_rom[i_s4[l] + IW'(1)];
			f_s5[l] <= f_s4[l];
			tu_s5[l] <= tu_s4[l];
			ub_s5[l] <= ub_s4[l];
			ta_s6[l] <= ta_s5[l];
			dfp_s6[l] <= dprod_c[l][48:18];
			tu_s6[l] <= tu_s5[l];
			ub_s6[l] <= ub_s5[l];
			e_s7[l] <= ta_s6[l] - dfp_s6[l];
			tu_s7[l] <= tu_s6[l];
			ub_s7[l] <= ub_s6[l];
			// t*e split in two partial products
			pl_s8[l] <= 48'(tu_s7[l][16:0]) * 48'(e_s7[l]);
			ph_s8[l] <= 47'(tu_s7[l][32:17]) * 47'(e_s7[l]);
			ub_s8[l] <= ub_s7[l];
			te_s9[l] <= tesum_c[l][62:30];
			ub_s9[l] <= ub_s8[l];
			sl_s10[l] <= scale_q * $signed({1'b0, te_s9[l][16:0]});
			sh_s10[l] <= scale_q * $signed({1'b0, te_s9[l][32:17]});
			ub_s10[l] <= ub_s9[l];
			pulse_s11[l] <= ub_s10[l] ? 41'(baseline_q)
				: 41'(baseline_q) + 41'($signed(psum_c[l][57:18]));
		end
		wp_s12 <= pulse_s11[0] * W_PLUS;
		wz_s12 <= pulse_s11[1] * W_ZERO;
		wm_s12 <= pulse_s11[2] * W_MINUS;
		if (rnd_c > 45'sd2147483647) begin
			model_value_s13 <= 32'sh7fffffff;
			saturated_s13 <= 1'b1;
		end else if (rnd_c < -45'sd2147483648) begin
			model_value_s13 <= 32'sh80000000;
			saturated_s13 <= 1'b1;
		end else begin
			model_value_s13 <= rnd_c[31:0];
			saturated_s13 <= 1'b0;
		end
	end

	// restoring divider t / tau, one quotient bit per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int J = DIV_STEPS - 1 - k;
		logic [32:0] rin [LANES];
		logic [17:0] qin [LANES];
		logic [32:0] tin [LANES];
		logic        uin [LANES];
		logic        vin;
		logic [32:0] dsh;

		assign dsh = 33'(tau_eff) << J;

		if (k == 0) begin : g_head
			assign vin = vld_s2;
			for (genvar l = 0; l < LANES; l++) begin : g_lane
				assign rin[l] = tu_s2[l];
				assign qin[l] = 18'd0;
				assign tin[l] = tu_s2[l];
				assign uin[l] = ub_s2[l];
			end
		end else begin : g_tail
			assign vin = dv_vld_s3[k-1];
			for (genvar l = 0; l < LANES; l++) begin : g_lane
				assign rin[l] = dv_rem_s3[k-1][l];
				assign qin[l] = dv_quo_s3[k-1][l];
				assign tin[l] = dv_tu_s3[k-1][l];
				assign uin[l] = dv_ub_s3[k-1][l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s3[k] <= 1'b0;
			end else begin
				dv_vld_s3[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			for (int l = 0; l < LANES; l++) begin
				if (rin[l] >= dsh) begin
					dv_rem_s3[k][l] <= rin[l] - dsh;
					dv_quo_s3[k][l] <= {qin[l][16:0], 1'b1};
				end else begin
					dv_rem_s3[k][l] <= rin[l];
					dv_quo_s3[k][l] <= {qin[l][16:0], 1'b0};
				end
				dv_tu_s3[k][l] <= tin[l];
				dv_ub_s3[k][l] <= uin[l];
			end
		end
	end

	assign done = vld_s13;
	assign model_value = model_value_s13;
	assign saturated = saturated_s13;

	`DCRRC_ASSERT_SAME(a_sat_clips, done && saturated, (model_value == 32'sh7fffffff) || (model_value == 32'sh80000000), "saturated result not at a range limit")
	`DCRRC_ASSERT_SAME(a_div_rem, dv_vld_s3[DIV_STEPS-1], dv_ub_s3[DIV_STEPS-1][1] || (dv_rem_s3[DIV_STEPS-1][1] < 33'(tau_eff)), "divider remainder not below tau")
	`DCRRC_ASSERT_NEXT(a_div_to_tab, dv_vld_s3[DIV_STEPS-1], vld_s4, "divider output lost before table stage")

endmodule

/* tb/deconvolved_crrc_pulse_model_test.sv */
module deconvolved_crrc_pulse_model_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dcrrc_pkg::*;

	localparam int ENTRIES = 256;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [2:0] REG_UNMAPPED = 3'd5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [15:0] time_in = '0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic busy, done, saturated, pready;
	logic signed [31:0] model_value;
	logic [31:0] prdata;

	deconvolved_crrc_pulse_model #(.EXP_TABLE_ENTRIES(ENTRIES)) DUT (
		.clk, .arst_n, .start, .busy, .time_in, .done, .model_value, .saturated,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	always #1 clk = ~clk;

	typedef struct packed {
		logic signed [31:0] value;
		logic               sat;
	} pulse_result_t;

	// shaping registers as the block should hold them
	logic signed [23:0] cur_baseline;
	logic signed [15:0] cur_offset;
	logic signed [23:0] cur_scale;
	logic [14:0]        cur_tau;
	logic [15:0]        cur_stretch;

	longint unsigned decay_tab [0:ENTRIES];
	pulse_result_t   pending_results [$];
	int errors = 0, items_sent = 0, results_seen = 0, sat_seen = 0, idle_cycles = 0;
	int gap_pct = 0;
	bit typed_ok = 1'b0;

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch on %s: got %0d, wanted %0d (result %0d)", what, got, want,
			results_seen);
	endtask

	function automatic void build_decay_table();
		longint unsigned step, term, q;
		longint acc;
		step = (64'd16 << 30) / ENTRIES;
		term = 64'd1 << 30;
		acc = longint'(64'd1 << 30);
		for (int n = 1; n <= 24; n++) begin
			term = ((term * step) >> 30) / n;
			if (n % 2) acc -= longint'(term);
			else acc += longint'(term);
		end
		q = (acc < 0) ? 64'd0 : longint'(acc);
		decay_tab[0] = 64'd1 << 30;
		for (int k = 1; k <= ENTRIES; k++)
			decay_tab[k] = (decay_tab[k-1] * q + (64'd1 << 29)) >> 30;
	endfunction

	function automatic longint round_half_up(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// shaper output at one shifted time, Q.8
	function automatic longint shaper_at(input longint tx);
		longint t;
		longint unsigned tu, tau, ratio, pos, idx, frac, decay, te;
		t = tx * longint'(cur_stretch) + longint'(cur_offset) * 16384;
		if (t <= 0) return longint'(cur_baseline);
		tau = (cur_tau < TAU_MIN) ? TAU_MIN : cur_tau;
		tu = t;
		ratio = tu / tau;
		pos = ratio * ENTRIES;
		idx = pos >> 18;
		if (idx >= ENTRIES) begin
			decay = 0;
		end else begin
			frac = pos & ((64'd1 << 18) - 1);
			decay = decay_tab[idx] - (((decay_tab[idx] - decay_tab[idx+1]) * frac) >> 18);
		end
		te = (tu * decay + (64'd1 << 29)) >> 30;
		return longint'(cur_baseline) + round_half_up(longint'(cur_scale) * longint'(te), 18);
	endfunction

	function automatic pulse_result_t deconvolved_value(input logic signed [15:0] x);
		longint acc, res;
		pulse_result_t r;
		acc = longint'(W_PLUS) * shaper_at(longint'(x) + LANE_DELTA[0])
			- longint'(W_ZERO) * shaper_at(longint'(x))
			+ longint'(W_MINUS) * shaper_at(longint'(x) + LANE_DELTA[2]);
		res = round_half_up(acc, 14);
		r.sat = 1'b0;
		if (res > 64'sd2147483647) begin
			res = 64'sd2147483647;
			r.sat = 1'b1;
		end else if (res < -64'sd2147483648) begin
			res = -64'sd2147483648;
			r.sat = 1'b1;
		end
		r.value = res[31:0];
		return r;
	endfunction

	// transfers on both sides, plus the watchdog
	always @(posedge clk) begin
		bit moved;
		pulse_result_t want;
		moved = 1'b0;
		if (arst_n && start && !busy) begin
			pending_results.push_back(deconvolved_value(time_in));
			moved = 1'b1;
		end
		if (arst_n && done) begin
			moved = 1'b1;
			results_seen++;
			if (pending_results.size() == 0) begin
				report("unexpected result", model_value, 0);
			end else begin
				want = pending_results.pop_front();
				if (model_value !== want.value) report("model_value", model_value, want.value);
				if (saturated !== want.sat) report("saturated", saturated, want.sat);
				if (want.sat) sat_seen++;
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_time(input logic signed [15:0] x);
		// each cycle the sender idles with the chance gap_pct
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		time_in <= x;
		forever begin
			bit ready;
			@(negedge clk);
			ready = !busy;
			@(posedge clk);
			if (ready) break;
		end
		items_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		logic [31:0] mask;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		mask = 32'd0;
		case (idx)
			REG_BASELINE: begin
				cur_baseline = data[23:0];
				mask = 32'h00FFFFFF;
			end
			REG_OFFSET: begin
				cur_offset = data[15:0];
				mask = 32'h0000FFFF;
			end
			REG_SCALE: begin
				cur_scale = data[23:0];
				mask = 32'h00FFFFFF;
			end
			REG_TAU: begin
				cur_tau = data[14:0];
				mask = 32'h00007FFF;
			end
			REG_STRETCH: begin
				cur_stretch = data[15:0];
				mask = 32'h0000FFFF;
			end
			default: ;
		endcase
		// read back the register just written
		@(negedge clk);
		if (idx < REG_UNMAPPED && prdata !== (data & mask))
			report("register read-back", prdata, data & mask);
		@(posedge clk);
	endtask

	task automatic load_shaping(input logic [23:0] b, input logic [15:0] o,
			input logic [23:0] s, input logic [14:0] tau, input logic [15:0] st);
		write_reg(REG_BASELINE, {8'd0, b});
		write_reg(REG_OFFSET, {16'd0, o});
		write_reg(REG_SCALE, {8'd0, s});
		write_reg(REG_TAU, {17'd0, tau});
		write_reg(REG_STRETCH, {16'd0, st});
	endtask

	typedef struct {
		logic signed [15:0] x;
		bit                 typed;
		logic signed [31:0] value;
		logic               sat;
	} time_row_t;

	// typed rows only hold under the reset settings: all three lanes sit before turn-on
	time_row_t time_rows [] = '{
		'{16'sh8000,   1'b1, 32'sd0, 1'b0},
		'{-16'sd5000,  1'b1, 32'sd0, 1'b0},
		'{16'sd32767,  1'b0, 32'sd0, 1'b0},
		'{16'sd0,      1'b0, 32'sd0, 1'b0},
		'{-16'sd1,     1'b0, 32'sd0, 1'b0},
		'{16'sd1,      1'b0, 32'sd0, 1'b0},
		'{16'sd160,    1'b0, 32'sd0, 1'b0},
		'{16'sd400,    1'b0, 32'sd0, 1'b0},
		'{-16'sd400,   1'b0, 32'sd0, 1'b0},
		'{16'sd560,    1'b0, 32'sd0, 1'b0},
		'{16'sd960,    1'b0, 32'sd0, 1'b0},
		'{16'sd1500,   1'b0, 32'sd0, 1'b0},
		'{16'sd3000,   1'b0, 32'sd0, 1'b0},
		'{16'sd12000,  1'b0, 32'sd0, 1'b0},
		'{16'sd24000,  1'b0, 32'sd0, 1'b0},
		'{16'h5555,    1'b0, 32'sd0, 1'b0},
		'{-16'sd21846, 1'b0, 32'sd0, 1'b0}
	};

	task automatic walk_rows();
		foreach (time_rows[i]) begin
			// typed value must agree with the predictor for this row
			if (typed_ok && time_rows[i].typed) begin
				pulse_result_t r;
				r = deconvolved_value(time_rows[i].x);
				if (r.value !== time_rows[i].value || r.sat !== time_rows[i].sat)
					report("typed row prediction", r.value, time_rows[i].value);
			end
			send_time(time_rows[i].x);
		end
	endtask

	task automatic random_times(input int n);
		repeat (n) begin
			if ($urandom_range(1)) send_time(16'($urandom));
			else send_time(16'($signed($urandom_range(8000)) - 2000));
		end
	endtask

	initial begin
		build_decay_table();
		cur_baseline = '0;
		cur_offset = -16'sd560;
		cur_scale = 24'sd46080;
		cur_tau = 15'd720;
		cur_stretch = 16'd16384;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		typed_ok = 1'b1;
		walk_rows();
		typed_ok = 1'b0;
		random_times(80);
		drain();

		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: load_shaping(24'h7FFFFF, 16'h7FFF, 24'h7FFFFF, 15'd16, 16'hFFFF);
				1: load_shaping(24'h800000, 16'h8000, 24'h800000, 15'h7FFF, 16'd0);
				2: load_shaping(24'h000100, 16'd0, 24'h800000, 15'd3, 16'hFFFF);
				3: load_shaping(24'hFFFF00, 16'hFE00, 24'd25600, 15'd0, 16'd8192);
				default: begin
					load_shaping(24'($urandom), 16'($urandom),
						$urandom_range(1) ? 24'($urandom) : 24'($signed($urandom_range(131072)) - 65536),
						15'($urandom_range(32767)), 16'($urandom));
				end
			endcase
			if (phase == 2) write_reg(REG_UNMAPPED, $urandom);
			case (phase % 4)
				0: gap_pct = 0;
				1: gap_pct = 56;
				2: gap_pct = 10;
				default: gap_pct = 56;
			endcase
			walk_rows();
			random_times(65);
			drain();
		end

		$display("%0d times sent, %0d results checked, %0d clipped, across 10 register settings",
			items_sent, results_seen, sat_seen);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
